/* design/d6dwt_pkg.sv */
// d6dwt_pkg: shared constants and types for the d6 forward wavelet block
// no dependencies
`default_nettype none
package d6dwt_pkg;
  localparam int unsigned MaxLength = 64;
  localparam int unsigned NTaps = 6;
  localparam int unsigned FracBits = 17;
  localparam int unsigned WorkW = 24;
  localparam int unsigned TapW = 18;
  localparam int unsigned AccW = 48;

  function automatic logic signed [TapW-1:0] lo_tap(input logic [2:0] k);
    case (k)
      3'd0: lo_tap = 18'sd43604;
      3'd1: lo_tap = 18'sd105761;
      3'd2: lo_tap = 18'sd60277;
      3'd3: lo_tap = -18'sd17696;
      3'd4: lo_tap = -18'sd11199;
      3'd5: lo_tap = 18'sd4617;
      default: lo_tap = '0;
    endcase
  endfunction

  function automatic logic signed [TapW-1:0] hi_tap(input logic [2:0] k);
    case (k)
      3'd0: hi_tap = 18'sd4617;
      3'd1: hi_tap = 18'sd11199;
      3'd2: hi_tap = -18'sd17696;
      3'd3: hi_tap = -18'sd60277;
      3'd4: hi_tap = 18'sd105761;
      3'd5: hi_tap = -18'sd43604;
      default: hi_tap = '0;
    endcase
  endfunction

  typedef enum logic [2:0] {
    OpIdle,
    OpLoad,
    OpClear,
    OpMac,
    OpWrite,
    OpCopy,
    OpEmit
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [5:0] rd_addr;
    logic [5:0] wr_addr;
    logic [5:0] wr_addr_hi;
    logic [2:0] tap;
    logic       last;
  } cmd_t;
endpackage
`default_nettype wire

/* design/d6dwt_datapath.sv */
// d6dwt_datapath: work and level stores, two multiply-accumulate units, rounding
// depends on d6dwt_pkg
`default_nettype none
module d6dwt_datapath #(
  parameter int unsigned MaxLength = d6dwt_pkg::MaxLength,
  localparam int unsigned AW = (MaxLength > 1) ? $clog2(MaxLength) : 1
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  d6dwt_pkg::cmd_t     cmd_i,
  input  wire  signed [15:0]  sample_i,
  output logic                strobe_o,
  output logic signed [23:0]  coefficient_o,
  output logic [5:0]          position_o,
  output logic                last_o
);
  logic signed [23:0] work_mem [MaxLength];
  logic signed [23:0] level_mem [MaxLength];
  logic signed [23:0] work_rd_q, level_rd_q;
  logic signed [15:0] sample_q;
  d6dwt_pkg::cmd_t    cmd_q;
  logic signed [47:0] lo_acc_q, hi_acc_q;
  logic signed [41:0] lo_prod, hi_prod;
  logic signed [23:0] lo_sat, hi_sat;

  function automatic logic signed [23:0] round_sat(input logic signed [47:0] a);
    logic signed [47:0] r;
    r = (a + 48'sd65536) >>> 17;
    if (r > 48'sd8388607) round_sat = 24'sh7fffff;
    else if (r < -48'sd8388608) round_sat = 24'sh800000;
    else round_sat = r[23:0];
  endfunction

  assign lo_prod = work_rd_q * d6dwt_pkg::lo_tap(cmd_q.tap);
  assign hi_prod = work_rd_q * d6dwt_pkg::hi_tap(cmd_q.tap);
  assign lo_sat = round_sat(lo_acc_q);
  assign hi_sat = round_sat(hi_acc_q);

  always_ff @(posedge clk_i) begin
    sample_q   <= sample_i;
    work_rd_q  <= work_mem[cmd_i.rd_addr[AW-1:0]];
    level_rd_q <= level_mem[cmd_i.rd_addr[AW-1:0]];
    if (cmd_i.op == d6dwt_pkg::OpLoad) begin
      work_mem[cmd_i.wr_addr[AW-1:0]] <= 24'(sample_q);
    end
    if (cmd_q.op == d6dwt_pkg::OpCopy) begin
      work_mem[cmd_q.wr_addr[AW-1:0]] <= level_rd_q;
    end
    if (cmd_q.op == d6dwt_pkg::OpWrite) begin
      level_mem[cmd_q.wr_addr[AW-1:0]]    <= lo_sat;
      level_mem[cmd_q.wr_addr_hi[AW-1:0]] <= hi_sat;
    end
    case (cmd_q.op)
      d6dwt_pkg::OpClear: begin
        lo_acc_q <= '0;
        hi_acc_q <= '0;
      end
      d6dwt_pkg::OpMac: begin
        lo_acc_q <= lo_acc_q + 48'(lo_prod);
        hi_acc_q <= hi_acc_q + 48'(hi_prod);
      end
      default: begin
      end
    endcase
    coefficient_o <= work_rd_q;
    position_o    <= cmd_q.wr_addr;
    last_o        <= cmd_q.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q    <= '0;
      strobe_o <= 1'b0;
    end else begin
      cmd_q    <= cmd_i;
      strobe_o <= (cmd_q.op == d6dwt_pkg::OpEmit);
    end
  end
endmodule
`default_nettype wire

/* design/d6dwt_ctrl.sv */
// d6dwt_ctrl: sequencer for loading, per-level filtering, copy-back and drain
// depends on d6dwt_pkg
`default_nettype none
module d6dwt_ctrl #(
  parameter int unsigned MaxLength = d6dwt_pkg::MaxLength
) (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             start_i,
  input  wire             cfg_valid_i,
  input  wire  [2:0]      cfg_data_i,
  output logic            busy_o,
  output d6dwt_pkg::cmd_t cmd_o
);
  localparam int unsigned MaxLog = (MaxLength >= 64) ? 6 : $clog2(MaxLength + 1) - 1;

  typedef enum logic [2:0] {
    StLoad, StClear, StMac, StWrite, StCopy, StEmit, StWait
  } state_e;

  state_e     state_q;
  logic [2:0] lg_q;
  logic [6:0] cnt_q;
  logic [6:0] j_q;
  logic [6:0] i_q;
  logic [2:0] k_q;
  logic [2:0] wait_q;
  logic [6:0] n;
  logic [2:0] lg_eff;

  always_comb begin
    lg_eff = lg_q;
    if (lg_eff < 3'd1) lg_eff = 3'd1;
    if (lg_eff > 3'(MaxLog)) lg_eff = 3'(MaxLog);
    n = 7'd1 << lg_eff;
  end

  assign busy_o = (state_q != StLoad);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
      lg_q    <= 3'd6;
      cnt_q   <= '0;
      j_q     <= '0;
      i_q     <= '0;
      k_q     <= '0;
      wait_q  <= '0;
      cmd_o   <= '0;
    end else begin
      cmd_o <= '0;
      if (cfg_valid_i) begin
        lg_q  <= cfg_data_i;
        cnt_q <= '0;
      end
      case (state_q)
        StLoad: begin
          if (start_i && !cfg_valid_i) begin
            cmd_o.op      <= d6dwt_pkg::OpLoad;
            cmd_o.wr_addr <= cnt_q[5:0];
            if (cnt_q + 7'd1 >= n) begin
              cnt_q   <= '0;
              j_q     <= n;
              i_q     <= '0;
              state_q <= StClear;
            end else begin
              cnt_q <= cnt_q + 7'd1;
            end
          end
        end
        StClear: begin
          cmd_o.op <= d6dwt_pkg::OpClear;
          k_q      <= '0;
          state_q  <= StMac;
        end
        StMac: begin
          cmd_o.op      <= d6dwt_pkg::OpMac;
          cmd_o.tap     <= k_q;
          cmd_o.rd_addr <= 6'((i_q + 7'(k_q)) & (j_q - 7'd1));
          if (k_q == 3'd5) state_q <= StWrite;
          else k_q <= k_q + 3'd1;
        end
        StWrite: begin
          // first slot waits so the final product lands
          if (wait_q == 3'd0) begin
            wait_q <= 3'd1;
          end else begin
            wait_q           <= '0;
            cmd_o.op         <= d6dwt_pkg::OpWrite;
            cmd_o.wr_addr    <= 6'(i_q >> 1);
            cmd_o.wr_addr_hi <= 6'((i_q >> 1) + (j_q >> 1));
            if (i_q + 7'd2 >= j_q) begin
              i_q     <= '0;
              state_q <= StCopy;
            end else begin
              i_q     <= i_q + 7'd2;
              state_q <= StClear;
            end
          end
        end
        StCopy: begin
          // first slot lets the last level write settle
          if (wait_q == 3'd0) begin
            wait_q <= 3'd1;
          end else begin
            cmd_o.op      <= d6dwt_pkg::OpCopy;
            cmd_o.rd_addr <= i_q[5:0];
            cmd_o.wr_addr <= i_q[5:0];
            if (i_q + 7'd1 >= j_q) begin
              i_q    <= '0;
              j_q    <= j_q >> 1;
              wait_q <= '0;
              if (j_q == 7'd2) state_q <= StEmit;
              else state_q <= StClear;
            end else begin
              i_q <= i_q + 7'd1;
            end
          end
        end
        StEmit: begin
          // first slot lets the last copy beat settle
          if (wait_q == 3'd0) begin
            wait_q <= 3'd1;
          end else begin
            cmd_o.op      <= d6dwt_pkg::OpEmit;
            cmd_o.rd_addr <= i_q[5:0];
            cmd_o.wr_addr <= i_q[5:0];
            cmd_o.last    <= (i_q + 7'd1 == n);
            if (i_q + 7'd1 >= n) begin
              i_q     <= '0;
              wait_q  <= '0;
              state_q <= StWait;
            end else begin
              i_q <= i_q + 7'd1;
            end
          end
        end
        StWait: begin
          if (wait_q == 3'd3) begin
            wait_q  <= '0;
            state_q <= StLoad;
          end else begin
            wait_q <= wait_q + 3'd1;
          end
        end
        default: state_q <= StLoad;
      endcase
    end
  end
endmodule
`default_nettype wire

/* design/daubechies6_forward_dwt.sv */
// daubechies6_forward_dwt: multi-level d6 forward wavelet transform, periodic wrap
// one sample a cycle while loading, when start is high and no config is taken
// per output pair each level clears, runs the tap MACs and writes, then copies back
// then one coefficient a cycle; busy through filter and drain, then loading resumes
// reset: length 64, load count zero, stores undefined; receiver cannot stall
// depends on d6dwt_pkg, d6dwt_ctrl, d6dwt_datapath
`default_nettype none
module daubechies6_forward_dwt #(
  parameter int unsigned MaxLength = d6dwt_pkg::MaxLength
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                start,
  output logic               busy,
  input  wire  signed [15:0] sample_i,
  input  wire                cfg_valid,
  output logic               cfg_ready,
  input  wire  [2:0]         cfg_data_i,
  output logic               strobe,
  output logic signed [23:0] coefficient_o,
  output logic [5:0]         position_o,
  output logic               last_o
);
  d6dwt_pkg::cmd_t cmd;

  assign cfg_ready = !busy;

  d6dwt_ctrl #(.MaxLength(MaxLength)) u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .cfg_valid_i(cfg_valid & cfg_ready),
    .cfg_data_i, .busy_o(busy), .cmd_o(cmd)
  );

  d6dwt_datapath #(.MaxLength(MaxLength)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sample_i,
    .strobe_o(strobe), .coefficient_o, .position_o, .last_o
  );
endmodule
`default_nettype wire

/* dv/tb.sv */
// tb: self-checking testbench for daubechies6_forward_dwt, the d6 forward wavelet block
// random and directed sample blocks over all lengths; predicts each coefficient beat
// depends on d6dwt_pkg and the rtl of daubechies6_forward_dwt
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxLen = d6dwt_pkg::MaxLength;
  localparam int LoTaps[6] = '{43604, 105761, 60277, -17696, -11199, 4617};
  localparam int HiTaps[6] = '{4617, 11199, -17696, -60277, 105761, -43604};

  typedef struct {
    logic signed [23:0] coefficient;
    logic [5:0]         position;
    logic               last;
  } coef_t;

  typedef struct {
    bit                 is_cfg;
    logic signed [15:0] sample;
    logic [2:0]         len_code;
  } job_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic signed [15:0] sample_i;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [2:0]         cfg_data_i;
  logic               strobe;
  logic signed [23:0] coefficient_o;
  logic [5:0]         position_o;
  logic               last_o;

  daubechies6_forward_dwt u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .sample_i      (sample_i),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data_i    (cfg_data_i),
    .strobe        (strobe),
    .coefficient_o (coefficient_o),
    .position_o    (position_o),
    .last_o        (last_o)
  );

  job_t  pending_jobs[$];
  coef_t expected_coefs[$];
  int    mismatch_count = 0;
  int    beats_seen = 0;
  bit    driver_done = 0;

  logic [2:0]         length_code;
  int unsigned        samples_loaded;
  logic signed [23:0] block_buf[MaxLen];

  function automatic int unsigned block_length(input logic [2:0] code);
    int unsigned lg;
    lg = code;
    if (lg < 1) lg = 1;
    if (lg > 6) lg = 6;
    return 1 << lg;
  endfunction

  function automatic logic signed [23:0] round_saturate(input longint acc);
    longint r;
    r = (acc + 65536) >>> 17;
    if (r > 8388607) return 24'sh7fffff;
    if (r < -8388608) return -24'sh800000;
    return r[23:0];
  endfunction

  task automatic run_wavelet(input int unsigned n);
    logic signed [23:0] lvl[MaxLen];
    int unsigned j, i, k, idx;
    longint lo, hi;
    coef_t c;
    for (j = n; j >= 2; j = j >> 1) begin
      for (i = 0; i < j; i += 2) begin
        lo = 0;
        hi = 0;
        for (k = 0; k < 6; k++) begin
          idx = (i + k) & (j - 1);
          lo += longint'(block_buf[idx]) * LoTaps[k];
          hi += longint'(block_buf[idx]) * HiTaps[k];
        end
        lvl[i >> 1] = round_saturate(lo);
        lvl[(i >> 1) + (j >> 1)] = round_saturate(hi);
      end
      for (i = 0; i < j; i++) block_buf[i] = lvl[i];
    end
    for (i = 0; i < n; i++) begin
      c.coefficient = block_buf[i];
      c.position = i[5:0];
      c.last = (i + 1 == n);
      expected_coefs.push_back(c);
    end
  endtask

  task automatic predict_sample(input logic signed [15:0] s);
    int unsigned n;
    n = block_length(length_code);
    if (samples_loaded >= n) samples_loaded = 0;
    block_buf[samples_loaded] = 24'(s);
    samples_loaded++;
    if (samples_loaded == n) begin
      samples_loaded = 0;
      run_wavelet(n);
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch beat %0d %s: got %0d want %0d", beats_seen, what, got, want);
    mismatch_count++;
  endtask

  initial begin
    clk_i = 0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 15) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 3);
  endfunction

  // driver
  int  gap_left = 0;
  bit  quiet_phase = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 0;
      cfg_valid <= 0;
      sample_i <= '0;
      cfg_data_i <= '0;
      gap_left <= 0;
    end else begin
      job_t jb;
      if (start && !busy) predict_sample(sample_i);
      if (cfg_valid && cfg_ready) begin
        length_code = cfg_data_i;
        samples_loaded = 0;
      end
      if ((start && !busy) || (cfg_valid && cfg_ready) || (!start && !cfg_valid)) begin
        if (gap_left > 0 || pending_jobs.size() == 0) begin
          start <= 0;
          cfg_valid <= 0;
          if (gap_left > 0) gap_left <= gap_left - 1;
          else driver_done <= 1;
        end else if (pending_jobs[0].is_cfg && expected_coefs.size() != 0) begin
          start <= 0;
          cfg_valid <= 0;
        end else begin
          jb = pending_jobs.pop_front();
          start <= !jb.is_cfg;
          cfg_valid <= jb.is_cfg;
          sample_i <= jb.sample;
          cfg_data_i <= jb.len_code;
          gap_left <= quiet_phase ? 0 : gap_len();
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && strobe) begin
      coef_t w;
      if (expected_coefs.size() == 0) begin
        report_mismatch("unexpected beat", coefficient_o, 0);
      end else begin
        w = expected_coefs.pop_front();
        if (coefficient_o !== w.coefficient)
          report_mismatch("coefficient", coefficient_o, w.coefficient);
        if (position_o !== w.position) report_mismatch("position", position_o, w.position);
        if (last_o !== w.last) report_mismatch("last", last_o, w.last);
      end
      beats_seen++;
    end
  end

  task automatic add_cfg(input logic [2:0] code);
    job_t jb;
    jb.is_cfg = 1;
    jb.sample = '0;
    jb.len_code = code;
    pending_jobs.push_back(jb);
  endtask

  task automatic add_sample(input logic signed [15:0] s);
    job_t jb;
    jb.is_cfg = 0;
    jb.sample = s;
    jb.len_code = '0;
    pending_jobs.push_back(jb);
  endtask

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 16'sh7fff;
      1: return -16'sh8000;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int unsigned total;
    logic [2:0] code;
    rst_ni = 0;
    length_code = 3'd6;
    samples_loaded = 0;
    // directed: extremes at short lengths, out-of-range length code 0
    add_cfg(3'd1);
    add_sample(16'sh7fff);
    add_sample(-16'sh8000);
    add_cfg(3'd0);
    add_sample(-16'sh8000);
    add_sample(-16'sh8000);
    add_cfg(3'd2);
    add_sample(16'sh7fff);
    add_sample(-16'sh8000);
    add_sample(16'sh7fff);
    add_sample(-16'sh8000);
    add_cfg(3'd3);
    for (int i = 0; i < 8; i++) add_sample((i % 2) ? -16'sh8000 : 16'sh7fff);
    add_cfg(3'd2);
    add_sample(16'sh1234);
    add_sample(16'sh0001);
    add_cfg(3'd2);
    for (int i = 0; i < 4; i++) add_sample(16'hffff);
    // random: mostly short blocks, a few full 64-sample ones and code 7
    total = 0;
    while (total < 370) begin
      case ($urandom_range(0, 9))
        0: code = 3'd6;
        1: code = 3'd7;
        2: code = 3'd4;
        3: code = 3'd5;
        default: code = 3'($urandom_range(0, 3));
      endcase
      add_cfg(code);
      for (int b = 0; b < $urandom_range(1, 3); b++) begin
        for (int i = 0; i < block_length(code); i++) begin
          add_sample(rand_sample());
          total++;
        end
      end
      if ($urandom_range(0, 4) == 0) begin
        for (int i = 0; i < $urandom_range(1, 3); i++) begin
          add_sample(rand_sample());
          total++;
        end
      end
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    fork
      forever begin
        repeat ($urandom_range(50, 400)) @(posedge clk_i);
        quiet_phase <= ~quiet_phase;
      end
    join_none
    wait (driver_done && expected_coefs.size() == 0);
    repeat (1200) @(posedge clk_i);
    if (mismatch_count == 0 && expected_coefs.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("end of test: mismatches");
    $finish;
  end
endmodule
`default_nettype wire

/* daubechies6_forward_dwt.f */
design/d6dwt_pkg.sv
design/d6dwt_datapath.sv
design/d6dwt_ctrl.sv
design/daubechies6_forward_dwt.sv
dv/tb.sv
